// ===== rtl/core/itcg_pkg.sv =====
// Shared types, constants and helpers of the IP/TCP checksum generator.
// No dependencies; used by itcg_accum, itcg_fold and ip_tcp_checksum_generator.
package itcg_pkg;

  localparam int unsigned MAX_PACKET_WORDS_DEF = 32768;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned HDR_W  = 6;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned OFF_W  = 17;

  // Mode codes as sampled from the kind field
  localparam logic [KIND_W-1:0] MODE_IP  = 2'd0;
  localparam logic [KIND_W-1:0] MODE_TCP = 2'd1;

  localparam logic [OFF_W-1:0] IP_CKSUM_OFF  = 17'd10;
  localparam logic [OFF_W-1:0] TCP_CKSUM_OFF = 17'd16;
  localparam logic [OFF_W-1:0] ADDR_START    = 17'd12;
  localparam logic [OFF_W-1:0] ADDR_END      = 17'd20;
  localparam logic [WORD_W-1:0] PROTO_TCP    = 16'd6;

  // Snapshot of a packet's sum, handed to the fold stage on the last word
  typedef struct packed {
    logic [KIND_W-1:0] mode;
    logic [LEN_W-1:0]  length;
    logic [ACC_W-1:0]  acc;
  } snap_t;

  // Word at byte offset off of a region of len bytes; zero outside the region
  // and at the skipped checksum word, low byte dropped on an odd tail.
  function automatic logic [WORD_W-1:0] region_word(
    input logic [WORD_W-1:0] w,
    input logic [OFF_W-1:0]  off,
    input logic [LEN_W-1:0]  len,
    input logic [OFF_W-1:0]  skip
  );
    logic [WORD_W-1:0] res;
    res = w;
    if (off >= {1'b0, len} || off == skip) begin
      res = '0;
    end else if (off + 17'd1 == {1'b0, len}) begin
      res = {w[15:8], 8'h00};
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ip_tcp_checksum_generator.sv =====
// Top level of the IP header / TCP segment checksum generator.
// Depends on itcg_pkg, itcg_accum and itcg_fold.
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i/in_stall_o   data_word, kind, segment_length, first, last
//   output   out        out_valid_o/out_stall_i checksum, status
//
// One packet word is taken per cycle unless a word marked last waits on a blocked
// snapshot; the adder on the running sum and the word counter set that figure.
// A word marked last shows its result once it has passed the input register,
// then the sum snapshot, then the folded result register.
// Reset clears all control and packet state; no clearing pass is needed.
// A stall on the output holds the result register, then backs up through the
// snapshot and input registers; words without last keep flowing while only
// the snapshot is blocked.
module ip_tcp_checksum_generator #(
  parameter int unsigned MAX_PACKET_WORDS = itcg_pkg::MAX_PACKET_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [itcg_pkg::WORD_W-1:0]   data_word_i,
  input  logic [itcg_pkg::KIND_W-1:0]   kind_i,
  input  logic [itcg_pkg::LEN_W-1:0]    segment_length_i,
  input  logic                          first_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itcg_pkg::WORD_W-1:0]   checksum_o,
  output logic                          status_o
);

  logic            snap_valid;
  logic            snap_stall;
  itcg_pkg::snap_t snap;

  // Running sum and packet state
  itcg_accum #(
    .MAX_PACKET_WORDS(MAX_PACKET_WORDS)
  ) u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_word_i      (data_word_i),
    .kind_i           (kind_i),
    .segment_length_i (segment_length_i),
    .first_i          (first_i),
    .last_i           (last_i),
    .snap_valid_o     (snap_valid),
    .snap_o           (snap),
    .snap_stall_i     (snap_stall)
  );

  // Fold and complement into the result register
  itcg_fold u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_stall_o (snap_stall),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .checksum_o   (checksum_o),
    .status_o     (status_o)
  );

endmodule

// ===== rtl/core/itcg_accum.sv =====
// Input register, per-packet state and running sum of the checksum generator.
// Depends on itcg_pkg; feeds snapshots to itcg_fold.
module itcg_accum #(
  parameter int unsigned MAX_PACKET_WORDS = itcg_pkg::MAX_PACKET_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [itcg_pkg::WORD_W-1:0]   data_word_i,
  input  logic [itcg_pkg::KIND_W-1:0]   kind_i,
  input  logic [itcg_pkg::LEN_W-1:0]    segment_length_i,
  input  logic                          first_i,
  input  logic                          last_i,
  output logic                          snap_valid_o,
  output itcg_pkg::snap_t               snap_o,
  input  logic                          snap_stall_i
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKET_WORDS + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PACKET_WORDS);

  // Input register
  logic                        v1_q;
  logic [itcg_pkg::WORD_W-1:0] word_q;
  logic [itcg_pkg::KIND_W-1:0] kind_q;
  logic [itcg_pkg::LEN_W-1:0]  seglen_q;
  logic                        first_q;
  logic                        last_q;

  // Packet state
  logic [itcg_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic [itcg_pkg::HDR_W-1:0]  hdr_q, hdr_d;
  logic [itcg_pkg::KIND_W-1:0] mode_q, mode_d;
  logic [itcg_pkg::LEN_W-1:0]  len_q, len_d;

  logic            v2_q, v2_d;
  itcg_pkg::snap_t snap_q;

  logic s2_free, s1_go, s1_load;
  logic [IDX_W-1:0]            idx_eff;
  logic [itcg_pkg::ACC_W-1:0]  acc_base;
  logic [itcg_pkg::OFF_W-1:0]  boff, hdr_off;
  logic [itcg_pkg::WORD_W-1:0] add_a, add_b;
  logic                        in_range;

  assign s2_free    = !v2_q || !snap_stall_i;
  assign s1_go      = v1_q && (!last_q || s2_free);
  assign s1_load    = !v1_q || s1_go;
  assign in_stall_o = !s1_load;

  always_comb begin
    mode_d   = first_q ? kind_q : mode_q;
    len_d    = first_q ? seglen_q : len_q;
    hdr_d    = first_q ? {word_q[11:8], 2'b00} : hdr_q;
    idx_eff  = first_q ? '0 : idx_q;
    acc_base = first_q ? '0 : acc_q;
    in_range = idx_eff < IDX_MAX;
    boff     = itcg_pkg::OFF_W'({idx_eff, 1'b0});
    hdr_off  = itcg_pkg::OFF_W'(hdr_d);
    add_a    = '0;
    add_b    = '0;
    if (in_range) begin
      if (mode_d == itcg_pkg::MODE_IP) begin
        add_a = itcg_pkg::region_word(word_q, boff, len_d, itcg_pkg::IP_CKSUM_OFF);
      end else if (mode_d == itcg_pkg::MODE_TCP) begin
        if (boff >= itcg_pkg::ADDR_START && boff < itcg_pkg::ADDR_END) begin
          add_a = word_q;
        end
        if (boff >= hdr_off) begin
          add_b = itcg_pkg::region_word(word_q, boff - hdr_off, len_d,
                                        itcg_pkg::TCP_CKSUM_OFF);
        end
      end
    end
    acc_d = acc_base + itcg_pkg::ACC_W'(add_a) + itcg_pkg::ACC_W'(add_b);
    idx_d = in_range ? idx_eff + IDX_W'(1) : idx_eff;
    v2_d  = v2_q;
    if (s2_free) begin
      v2_d = s1_go && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      acc_q  <= '0;
      idx_q  <= '0;
      hdr_q  <= '0;
      mode_q <= '0;
      len_q  <= '0;
    end else begin
      if (s1_load) begin
        v1_q <= in_valid_i;
      end
      v2_q <= v2_d;
      if (s1_go) begin
        acc_q  <= acc_d;
        idx_q  <= idx_d;
        hdr_q  <= hdr_d;
        mode_q <= mode_d;
        len_q  <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      word_q   <= data_word_i;
      kind_q   <= kind_i;
      seglen_q <= segment_length_i;
      first_q  <= first_i;
      last_q   <= last_i;
    end
    if (s2_free && s1_go && last_q) begin
      snap_q.mode   <= mode_d;
      snap_q.length <= len_d;
      snap_q.acc    <= acc_d;
    end
  end

  assign snap_valid_o = v2_q;
  assign snap_o       = snap_q;

endmodule

// ===== rtl/core/itcg_fold.sv =====
// Fold, pseudo-header add and complement, with the result register.
// Depends on itcg_pkg; takes snapshots from itcg_accum.
module itcg_fold (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        snap_valid_i,
  input  itcg_pkg::snap_t             snap_i,
  output logic                        snap_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [itcg_pkg::WORD_W-1:0] checksum_o,
  output logic                        status_o
);

  logic                        out_valid_q;
  logic [itcg_pkg::WORD_W-1:0] checksum_q, checksum_d;
  logic                        status_q, status_d;
  logic                        load;
  logic [16:0]                 s1, t2;
  logic [15:0]                 s2, t3;
  logic [17:0]                 t1;

  assign load         = !out_valid_q || !out_stall_i;
  assign snap_stall_o = !load;

  always_comb begin
    s1 = {1'b0, snap_i.acc[15:0]} + {1'b0, snap_i.acc[31:16]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    t1 = {2'b00, s2} + {2'b00, itcg_pkg::PROTO_TCP} + {2'b00, snap_i.length};
    t2 = {1'b0, t1[15:0]} + {15'd0, t1[17:16]};
    t3 = t2[15:0] + {15'd0, t2[16]};
    if (snap_i.mode == itcg_pkg::MODE_IP) begin
      checksum_d = ~s2;
      status_d   = 1'b0;
    end else if (snap_i.mode == itcg_pkg::MODE_TCP) begin
      checksum_d = ~t3;
      status_d   = 1'b0;
    end else begin
      checksum_d = '0;
      status_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && snap_valid_i) begin
      checksum_q <= checksum_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;
  assign status_o    = status_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ip_tcp_checksum_generator: IP header and TCP segment checksums.
// Depends on itcg_pkg and the generator RTL; holds its own checksum predictor.
module tb_top;

  // Shrink the word limit so that over-long packets are cheap to reach
  localparam int unsigned PKT_WORD_LIMIT = 64;
  localparam int unsigned N_ITEMS = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 32;

  // Kind codes beyond the two supported modes
  localparam logic [itcg_pkg::KIND_W-1:0] KIND_RSVD2 = 2'd2;
  localparam logic [itcg_pkg::KIND_W-1:0] KIND_RSVD3 = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef struct packed {
    logic [itcg_pkg::WORD_W-1:0] word;
    logic [itcg_pkg::KIND_W-1:0] kind;
    logic [itcg_pkg::LEN_W-1:0]  seg_len;
    logic                        first;
    logic                        last;
  } pkt_word_t;

  typedef struct packed {
    logic [itcg_pkg::WORD_W-1:0] checksum;
    logic                        status;
  } cksum_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel, driven from the pending word queue
  logic      in_valid = 1'b0;
  logic      in_stall;
  pkt_word_t cur_word = '0;

  // Output channel
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [itcg_pkg::WORD_W-1:0] checksum;
  logic                        status;

  pkt_word_t     pending_words[$];
  cksum_result_t expected_sums[$];
  pkt_word_t     next_word;
  cksum_result_t want_sum;

  // Predictor state: running sum and the fields latched on a first word
  logic [itcg_pkg::ACC_W-1:0]  sum_acc = '0;
  int unsigned                 word_idx = 0;
  logic [itcg_pkg::HDR_W-1:0]  hdr_bytes = '0;
  logic [itcg_pkg::KIND_W-1:0] mode_q = itcg_pkg::MODE_IP;
  logic [itcg_pkg::LEN_W-1:0]  len_q = '0;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned n_errors = 0;

  ip_tcp_checksum_generator #(
    .MAX_PACKET_WORDS(PKT_WORD_LIMIT)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_word_i     (cur_word.word),
    .kind_i          (cur_word.kind),
    .segment_length_i(cur_word.seg_len),
    .first_i         (cur_word.first),
    .last_i          (cur_word.last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .checksum_o      (checksum),
    .status_o        (status)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Word at byte offset off of a region of len bytes: zero past the end and on
  // the checksum word, low byte cleared on an odd tail.
  function automatic logic [itcg_pkg::WORD_W-1:0] masked_word(
    input logic [itcg_pkg::WORD_W-1:0] w,
    input int unsigned off,
    input int unsigned len,
    input int unsigned skip
  );
    if (off >= len || off == skip) return '0;
    if (off + 1 == len) return {w[15:8], 8'h00};
    return w;
  endfunction

  // End-around carry fold down to 16 bits
  function automatic logic [itcg_pkg::WORD_W-1:0] fold_carries(
    input logic [itcg_pkg::ACC_W-1:0] s
  );
    logic [itcg_pkg::ACC_W-1:0] t;
    t = s;
    while (t[31:16] != '0) t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t[15:0];
  endfunction

  // Advance the predicted sum by one accepted word; queue a result on last
  task automatic predict_checksum(input pkt_word_t it);
    int unsigned   boff;
    logic [15:0]   s;
    cksum_result_t res;
    if (it.first) begin
      mode_q = it.kind;
      len_q = it.seg_len;
      hdr_bytes = {it.word[11:8], 2'b00};
      sum_acc = '0;
      word_idx = 0;
    end
    // Words past the word limit are dropped from the sum
    if (word_idx < PKT_WORD_LIMIT) begin
      boff = word_idx * 2;
      if (mode_q == itcg_pkg::MODE_IP) begin
        sum_acc += masked_word(it.word, boff, len_q, itcg_pkg::IP_CKSUM_OFF);
      end else if (mode_q == itcg_pkg::MODE_TCP) begin
        // Address words and segment words are summed independently: with a
        // short header one word may count twice
        if (boff >= itcg_pkg::ADDR_START && boff < itcg_pkg::ADDR_END) begin
          sum_acc += it.word;
        end
        if (boff >= hdr_bytes) begin
          sum_acc += masked_word(it.word, boff - hdr_bytes, len_q,
                                 itcg_pkg::TCP_CKSUM_OFF);
        end
      end
      word_idx++;
    end
    if (it.last) begin
      if (mode_q != itcg_pkg::MODE_IP && mode_q != itcg_pkg::MODE_TCP) begin
        res.checksum = '0;
        res.status = STATUS_UNSUPPORTED;
      end else begin
        s = fold_carries(sum_acc);
        if (mode_q == itcg_pkg::MODE_TCP) begin
          s = fold_carries({16'h0, s} + 32'(itcg_pkg::PROTO_TCP) + 32'(len_q));
        end
        res.checksum = ~s;
        res.status = STATUS_OK;
      end
      expected_sums.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_word(input logic [itcg_pkg::WORD_W-1:0] w,
                          input logic [itcg_pkg::KIND_W-1:0] k,
                          input logic [itcg_pkg::LEN_W-1:0] len,
                          input logic f, input logic l);
    pending_words.push_back('{word: w, kind: k, seg_len: len, first: f, last: l});
  endtask

  // Queue one packet; the first word carries version 4 and the given IHL.
  // Kind and length on later words are random: the block must ignore them.
  task automatic add_packet(input logic [itcg_pkg::KIND_W-1:0] k,
                            input logic [itcg_pkg::LEN_W-1:0] len,
                            input logic [3:0] ihl, input int unsigned n_words,
                            input bit all_ones);
    logic [itcg_pkg::WORD_W-1:0] w;
    for (int unsigned i = 0; i < n_words; i++) begin
      w = all_ones ? 16'hFFFF : 16'($urandom);
      if (i == 0) w[15:8] = {4'h4, ihl};
      if (i == 0) begin
        add_word(w, k, len, 1'b1, n_words == 1);
      end else begin
        add_word(w, 2'($urandom), 16'($urandom), 1'b0, i == n_words - 1);
      end
    end
  endtask

  // Well-formed packet with random content; now and then too short, too long
  // or with a random length field
  task automatic add_random_packet();
    logic [itcg_pkg::KIND_W-1:0] k;
    logic [3:0]                  ihl;
    int unsigned                 len;
    int unsigned                 n_words;
    int unsigned                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) k = itcg_pkg::MODE_IP;
    else if (pick < 90) k = itcg_pkg::MODE_TCP;
    else k = $urandom_range(0, 1) ? KIND_RSVD2 : KIND_RSVD3;
    ihl = ($urandom_range(0, 99) < 85) ? 4'd5 : 4'($urandom);
    if (k == itcg_pkg::MODE_TCP) begin
      len = $urandom_range(0, 40);
      n_words = ihl * 2 + (len + 1) / 2;
    end else begin
      len = ihl * 4;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 60);
      n_words = (len + 1) / 2;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) len = $urandom_range(0, 65535);
    else if (pick < 14) n_words = n_words + $urandom_range(1, 4);
    else if (pick < 20 && n_words > 1) n_words = $urandom_range(1, n_words - 1);
    else if (pick < 24) n_words = $urandom_range(PKT_WORD_LIMIT - 2, PKT_WORD_LIMIT + 12);
    if (n_words == 0) n_words = 1;
    add_packet(k, 16'(len), ihl, n_words, 1'b0);
  endtask

  task automatic add_noise_words(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      add_word(16'($urandom), 2'($urandom), 16'($urandom),
               $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    // One-word packets: extremes of the word and length, both supported modes
    add_word(16'hFFFF, itcg_pkg::MODE_IP, 16'hFFFF, 1'b1, 1'b1);
    add_word(16'h0000, itcg_pkg::MODE_TCP, 16'h0000, 1'b1, 1'b1);
    // Unsupported kinds report an error status
    add_word(16'($urandom), KIND_RSVD2, 16'($urandom), 1'b1, 1'b1);
    add_word(16'($urandom), KIND_RSVD3, 16'($urandom), 1'b1, 1'b1);
    // IP header of all-ones words with an odd length: carries and pad byte
    add_packet(itcg_pkg::MODE_IP, 16'd19, 4'hF, 10, 1'b1);
    // TCP with a one-word header: address and segment words overlap
    add_packet(itcg_pkg::MODE_TCP, 16'd21, 4'h1, 11, 1'b0);
    // Repeated last without a new first adds to the running sum and reports it again
    add_word(16'hA5A5, KIND_RSVD3, 16'h5A5A, 1'b0, 1'b1);

    // Mostly well-formed packets, with bursts of noise and broken framing
    while (pending_words.size() < N_ITEMS) begin
      if ($urandom_range(0, 99) < 82) add_random_packet();
      else add_noise_words($urandom_range(1, 4));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next word, hold it while stalled, then idle a drawn gap
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      // Predict at the edge where the transaction is taken
      if (in_valid && !in_stall) predict_checksum(cur_word);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          cur_word <= next_word;
          in_valid <= 1'b1;
          // Switch between back-to-back stretches and random gaps now and then
          if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
          gap_left = src_burst ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transaction, then stall the next one a drawn count
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected result checksum %h status %b",
                                    checksum, status));
        end else begin
          want_sum = expected_sums.pop_front();
          if (checksum !== want_sum.checksum) begin
            report_mismatch($sformatf("checksum got %h expected %h",
                                      checksum, want_sum.checksum));
          end
          if (status !== want_sum.status) begin
            report_mismatch($sformatf("status got %b expected %b",
                                      status, want_sum.status));
          end
        end
        if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
        stall_left = sink_burst ? 0 : $urandom_range(0, 19);
      end else if (out_valid && stall_left != 0) begin
        // Count stall cycles only while a result is actually waiting
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $realtime, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // End of test: drain all stimulus and results, give the pipe enough cycles
  // to show any stray result past the longest stall, then give the verdict
  initial begin
    @(posedge rst_ni);
    while (pending_words.size() != 0 || in_valid || expected_sums.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/itcg_pkg.sv
rtl/core/itcg_accum.sv
rtl/core/itcg_fold.sv
rtl/core/ip_tcp_checksum_generator.sv
tb/tb_top.sv
